// ===== hdl/ectd_pkg.sv =====
// Shared constants, types and helper functions for the epoch-to-civil converter.
`default_nettype none
package ectd_pkg;

  typedef logic [15:0] days_t;
  typedef logic [16:0] sod_t;
  typedef logic [17:0] doe_t;
  typedef logic [8:0]  doy_t;

  // Beat leaving the day split: whole days since the epoch and second of day.
  typedef struct packed {
    logic  valid;
    days_t days;
    sod_t  sod;
  } ectd_beat_t;

  // epoch / 86400 is taken as (epoch >> 7) / 675; floor reciprocal, one fix-up step.
  localparam logic [22:0] DAY_RECIP     = 23'd6362914;
  localparam logic [9:0]  DAY_ODD_DIV   = 10'd675;

  localparam logic [19:0] DAY_SHIFT     = 20'd719468;
  localparam int unsigned ERA_DAYS      = 146097;
  localparam int unsigned CENT_DAYS     = 36524;
  localparam logic [17:0] LAST_DOE      = 18'd146096;

  // Shared exact reciprocal: x * R >> 28 is x / 1460, x * R >> 26 is x / 365.
  localparam logic [17:0] RECIP_1460_365 = 18'd183860;
  localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
  localparam int unsigned YOE_CENT       = 100;

  // Exact reciprocals for (sod >> 4) / 225 and (rem >> 2) / 15.
  localparam logic [12:0] HOUR_RECIP    = 13'd4661;
  localparam logic [10:0] MIN_RECIP     = 11'd1093;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  localparam logic [3:0]  MP_JAN       = 4'd10;
  localparam logic [3:0]  MONTH_MAR    = 4'd3;
  localparam logic [3:0]  MP_TO_JAN    = 4'd9;

  // First day of year (counted from March 1) for each March-based month.
  function automatic doy_t month_start(input logic [3:0] mp);
    doy_t s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Start of the 400-year era that holds a shifted day count.
  function automatic logic [19:0] era_base(input logic [19:0] shifted);
    logic [19:0] base;
    logic [19:0] thr;
    base = 20'd0;
    for (int unsigned k = 1; k <= 5; k++) begin
      thr = 20'(k * ERA_DAYS);
      if (shifted >= thr) base = thr;
    end
    return base;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ectd_split.sv =====
// Front stages: split the epoch second count into whole days and second of day.
`default_nettype none
module ectd_split
  import ectd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [31:0] in_epoch_seconds,
  output ectd_beat_t       beat
);

  logic [47:0] quot_prod;
  logic [15:0] quot_nxt;

  logic        v1_r;
  logic [24:0] x1_r;
  logic [6:0]  lo1_r;
  logic [15:0] quot1_r;

  logic [24:0] back_prod;
  logic [24:0] rem;
  logic [10:0] rem_fix;
  logic        over;

  ectd_beat_t  beat_r;
  ectd_beat_t  beat_nxt;

  // Estimate is the true quotient or one below it.
  assign quot_prod = {23'd0, in_epoch_seconds[31:7]} * {25'd0, DAY_RECIP};
  assign quot_nxt  = quot_prod[47:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    x1_r    <= in_epoch_seconds[31:7];
    lo1_r   <= in_epoch_seconds[6:0];
    quot1_r <= quot_nxt;
  end

  assign back_prod = {9'd0, quot1_r} * {15'd0, DAY_ODD_DIV};
  assign rem       = x1_r - back_prod;
  assign over      = (rem[10:0] >= {1'b0, DAY_ODD_DIV});
  assign rem_fix   = over ? (rem[10:0] - {1'b0, DAY_ODD_DIV}) : rem[10:0];

  always_comb begin
    beat_nxt.valid = v1_r;
    beat_nxt.days  = quot1_r + {15'd0, over};
    beat_nxt.sod   = {rem_fix[9:0], lo1_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else begin
      beat_r.valid <= beat_nxt.valid;
    end
    beat_r.days <= beat_nxt.days;
    beat_r.sod  <= beat_nxt.sod;
  end

  assign beat = beat_r;

endmodule
`default_nettype wire

// ===== hdl/ectd_tod.sv =====
// Time-of-day pipeline: second of day to hours, minutes and seconds, six stages.
`default_nettype none
module ectd_tod
  import ectd_pkg::*;
(
  input  wire logic       clk,
  input  wire sod_t       sod,
  output logic [4:0]      hour,
  output logic [5:0]      minute,
  output logic [5:0]      second
);

  logic [25:0] hour_prod;
  logic [4:0]  hour_nxt;
  logic [16:0] back_hour;
  logic [16:0] rh_full;
  logic [20:0] min_prod;
  logic [5:0]  min_nxt;
  logic [11:0] back_min;
  logic [11:0] sec_full;

  sod_t        sod1_r;
  logic [4:0]  hour1_r, hour2_r, hour3_r, hour4_r, hour5_r, hour6_r;
  logic [11:0] rh2_r, rh3_r;
  logic [5:0]  min3_r, min4_r, min5_r, min6_r;
  logic [5:0]  sec4_r, sec5_r, sec6_r;

  assign hour_prod = {13'd0, sod[16:4]} * {13'd0, HOUR_RECIP};
  assign hour_nxt  = hour_prod[24:20];

  assign back_hour = {12'd0, hour1_r} * {5'd0, SECS_PER_HOUR};
  assign rh_full   = sod1_r - back_hour;

  assign min_prod  = {11'd0, rh2_r[11:2]} * {10'd0, MIN_RECIP};
  assign min_nxt   = min_prod[19:14];

  assign back_min  = {6'd0, min3_r} * {6'd0, SECS_PER_MIN};
  assign sec_full  = rh3_r - back_min;

  always_ff @(posedge clk) begin
    sod1_r  <= sod;
    hour1_r <= hour_nxt;
    rh2_r   <= rh_full[11:0];
    hour2_r <= hour1_r;
    rh3_r   <= rh2_r;
    min3_r  <= min_nxt;
    hour3_r <= hour2_r;
    sec4_r  <= sec_full[5:0];
    min4_r  <= min3_r;
    hour4_r <= hour3_r;
    // align with the date path
    sec5_r  <= sec4_r;
    min5_r  <= min4_r;
    hour5_r <= hour4_r;
    sec6_r  <= sec5_r;
    min6_r  <= min5_r;
    hour6_r <= hour5_r;
  end

  assign hour   = hour6_r;
  assign minute = min6_r;
  assign second = sec6_r;

endmodule
`default_nettype wire

// ===== hdl/ectd_date.sv =====
// Date pipeline: day count to civil day of month and month, six stages.
`default_nettype none
module ectd_date
  import ectd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire days_t      days,
  output logic            out_valid,
  output logic [4:0]      day,
  output logic [3:0]      month
);

  logic [19:0] shifted;
  logic [19:0] doe_full;
  logic [35:0] a_prod;
  logic [2:0]  cent_nxt;
  logic [17:0] n_nxt;
  logic [35:0] y_prod;
  logic [1:0]  ycent;
  logic [17:0] year_days;
  logic [17:0] doy_full;
  logic [3:0]  mp;
  doy_t        mstart;
  doy_t        day_full;

  logic        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  doe_t        doe1_r, doe2_r, doe3_r, doe4_r;
  logic [6:0]  a2_r;
  logic [2:0]  b2_r;
  logic        c2_r;
  logic [17:0] n3_r;
  logic [8:0]  yoe4_r;
  doy_t        doy5_r;
  logic [4:0]  day6_r;
  logic [3:0]  month6_r;

  assign shifted  = {4'd0, days} + DAY_SHIFT;
  assign doe_full = shifted - era_base(shifted);

  assign a_prod = {18'd0, doe1_r} * {18'd0, RECIP_1460_365};

  always_comb begin
    cent_nxt = 3'd0;
    for (int unsigned k = 1; k <= 4; k++) begin
      if (doe1_r >= 18'(k * CENT_DAYS)) cent_nxt = 3'(k);
    end
  end

  assign n_nxt  = doe2_r - {11'd0, a2_r} + {15'd0, b2_r} - {17'd0, c2_r};
  assign y_prod = {18'd0, n3_r} * {18'd0, RECIP_1460_365};

  always_comb begin
    ycent = 2'd0;
    for (int unsigned k = 1; k <= 3; k++) begin
      if (yoe4_r >= 9'(k * YOE_CENT)) ycent = 2'(k);
    end
  end

  assign year_days = {9'd0, yoe4_r} * {9'd0, DAYS_PER_YEAR}
                   + {11'd0, yoe4_r[8:2]} - {16'd0, ycent};
  assign doy_full  = doe4_r - year_days;

  // March-based month: last month whose first day is not past the day of year.
  always_comb begin
    mp = 4'd0;
    for (int unsigned m = 1; m <= 11; m++) begin
      if (doy5_r >= month_start(4'(m))) mp = 4'(m);
    end
  end

  assign mstart   = month_start(mp);
  assign day_full = doy5_r - mstart + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
    doe1_r   <= doe_full[17:0];
    a2_r     <= a_prod[34:28];
    b2_r     <= cent_nxt;
    c2_r     <= (doe1_r == LAST_DOE);
    doe2_r   <= doe1_r;
    n3_r     <= n_nxt;
    doe3_r   <= doe2_r;
    yoe4_r   <= y_prod[34:26];
    doe4_r   <= doe3_r;
    doy5_r   <= doy_full[8:0];
    day6_r   <= day_full[4:0];
    month6_r <= (mp < MP_JAN) ? (mp + MONTH_MAR) : (mp - MP_TO_JAN);
  end

  assign out_valid = v6_r;
  assign day       = day6_r;
  assign month     = month6_r;

endmodule
`default_nettype wire

// ===== hdl/epoch_to_civil_date_time.sv =====
// Top level: Unix epoch seconds to time of day, civil day of month and month.
//
// Issue a conversion by raising start with in_epoch_seconds for one cycle;
// busy is always low, so a new beat may be issued on every clock cycle.
// Each beat yields one result, shown for exactly one cycle with out_valid
// high on out_hour_of_day, out_minute_of_hour, out_second_of_minute,
// out_day_of_month and out_month_of_year. Results come back in issue order.
// The datapath is fully pipelined and takes one beat per cycle:
// two stages split the count into days and second of day (reciprocal
// multiply plus one fix-up), then six stages run the time-of-day and date
// paths side by side (era, year of era, day of year, month lookup).
// The receiver cannot stall the result channel, so results never wait.
// Synchronous reset (rst_n low) clears all valid bits; no result appears
// for beats in flight at reset. The other registers hold data only and are not reset.
`default_nettype none
module epoch_to_civil_date_time
  import ectd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_epoch_seconds,
  output logic             out_valid,
  output logic [4:0]       out_hour_of_day,
  output logic [5:0]       out_minute_of_hour,
  output logic [5:0]       out_second_of_minute,
  output logic [4:0]       out_day_of_month,
  output logic [3:0]       out_month_of_year
);

  ectd_beat_t beat;
  logic       accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  ectd_split u_split (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (accept),
    .in_epoch_seconds (in_epoch_seconds),
    .beat             (beat)
  );

  ectd_tod u_tod (
    .clk    (clk),
    .sod    (beat.sod),
    .hour   (out_hour_of_day),
    .minute (out_minute_of_hour),
    .second (out_second_of_minute)
  );

  ectd_date u_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (beat.valid),
    .days      (beat.days),
    .out_valid (out_valid),
    .day       (out_day_of_month),
    .month     (out_month_of_year)
  );

endmodule
`default_nettype wire
